// ===== rtl/dpcm_category_vlc_encoder_core_assert.svh =====
// assertion macros for the dpcm category vlc encoder core
// expects a clock named clock and a synchronous active-high reset named reset in scope
`ifndef DPCM_CATEGORY_VLC_ENCODER_CORE_ASSERT_SVH
`define DPCM_CATEGORY_VLC_ENCODER_CORE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define DCVE_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define DCVE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/dcve_pkg.sv =====
// shared types and prefix code tables for the dpcm category vlc encoder
// no dependencies
package dcve_pkg;

   // function codes of an input item
   localparam logic FUNC_CODE  = 1'b0;
   localparam logic FUNC_FLUSH = 1'b1;

   typedef struct packed {
      logic       func;
      logic [7:0] sample;
      logic       plane_start;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
   } rsp_type;

   // prefix code by category, right aligned
   function automatic logic [5:0] prefix_code(input logic [3:0] cat);
      logic [5:0] code;
      unique case (cat)
         4'd0:    code = 6'b000010;
         4'd1:    code = 6'b000011;
         4'd2:    code = 6'b000100;
         4'd3:    code = 6'b000000;
         4'd4:    code = 6'b000101;
         4'd5:    code = 6'b000110;
         4'd6:    code = 6'b001110;
         4'd7:    code = 6'b011110;
         4'd8:    code = 6'b111110;
         default: code = 6'b000000;
      endcase
      return code;
   endfunction

   // prefix code length by category
   function automatic logic [2:0] prefix_len(input logic [3:0] cat);
      logic [2:0] len;
      unique case (cat)
         4'd0, 4'd1, 4'd2, 4'd4, 4'd5: len = 3'd3;
         4'd3:    len = 3'd2;
         4'd6:    len = 3'd4;
         4'd7:    len = 3'd5;
         4'd8:    len = 3'd6;
         default: len = 3'd0;
      endcase
      return len;
   endfunction

endpackage

// ===== rtl/dpcm_category_vlc_encoder_core.sv =====
// An accepted item is held in the input register until the result buffer can take it;
// then its first byte, if it yields one, is presented on rsp_ from the result buffer.
// Throughput: one item per cycle while rsp_ready is high and each item yields at most one byte;
// an item that yields two bytes holds the single result buffer until both are taken, as the byte port is 8 bits.
// Reset clears predictor, pending bits and count, and both item registers' valid state.
// Depends on dcve_pkg and dpcm_category_vlc_encoder_core_assert.svh.
`include "dpcm_category_vlc_encoder_core_assert.svh"

module dpcm_category_vlc_encoder_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  dcve_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output dcve_pkg::rsp_type rsp_data
);

   // input register
   logic              in_valid_ff, in_valid_in;
   dcve_pkg::req_type in_item_ff, in_item_in;

   // coding state
   logic [7:0] pred_ff, pred_in;
   logic [6:0] pend_bits_ff, pend_bits_in;
   logic [2:0] pend_cnt_ff, pend_cnt_in;

   // result buffer: up to two bytes, count of bytes left
   logic [1:0] res_count_ff, res_count_in;
   logic [7:0] byte0_ff, byte0_in;
   logic [7:0] byte1_ff, byte1_in;

   logic       advance;
   logic       rsp_take;

   // datapath signals
   logic [7:0]  pred_sel;
   logic [8:0]  diff;
   logic        neg;
   logic [7:0]  mag;
   logic [3:0]  cat;
   logic [8:0]  mask9;
   logic [7:0]  mbits;
   logic [2:0]  plen;
   logic [20:0] acc;
   logic [4:0]  total;
   logic [23:0] window;
   logic [1:0]  nbytes;
   logic [7:0]  keep_mask;

   // handshake control
   assign rsp_valid = (res_count_ff != 2'd0);
   assign rsp_take  = rsp_valid && rsp_ready;
   assign advance   = in_valid_ff && ((res_count_ff == 2'd0) ||
                                      ((res_count_ff == 2'd1) && rsp_ready));
   assign req_ready = !in_valid_ff || advance;

   assign rsp_data.out_byte = byte0_ff;
   assign rsp_data.last     = (res_count_ff == 2'd1);

   // difference, magnitude and category
   always_comb begin
      pred_sel = in_item_ff.plane_start ? 8'd0 : pred_ff;
      diff     = {1'b0, in_item_ff.sample} - {1'b0, pred_sel};
      neg      = diff[8];
      mag      = neg ? (8'd0 - diff[7:0]) : diff[7:0];
      cat      = 4'd0;
      for (int i = 0; i < 8; i++) begin
         if (mag[i]) begin
            cat = 4'(i + 1);
         end
      end
      mask9 = (9'd1 << cat) - 9'd1;
      mbits = neg ? (~mag & mask9[7:0]) : mag;
      plen  = dcve_pkg::prefix_len(cat);
   end

   // bit accumulation and byte extraction
   always_comb begin
      if (in_item_ff.func == dcve_pkg::FUNC_FLUSH) begin
         acc    = 21'(pend_bits_ff);
         total  = 5'(pend_cnt_ff);
         nbytes = (pend_cnt_ff != 3'd0) ? 2'd1 : 2'd0;
      end else begin
         acc    = ((21'(pend_bits_ff) << plen) | 21'(dcve_pkg::prefix_code(cat)));
         acc    = (acc << cat) | 21'(mbits);
         total  = 5'(pend_cnt_ff) + 5'(plen) + 5'(cat);
         nbytes = total[4] ? 2'd2 : (total[3] ? 2'd1 : 2'd0);
      end
      window    = 24'(acc) << (5'd24 - total);
      keep_mask = (8'd1 << total[2:0]) - 8'd1;
   end

   // next-state logic
   always_comb begin
      in_valid_in  = in_valid_ff;
      in_item_in   = in_item_ff;
      pred_in      = pred_ff;
      pend_bits_in = pend_bits_ff;
      pend_cnt_in  = pend_cnt_ff;
      res_count_in = res_count_ff;
      byte0_in     = byte0_ff;
      byte1_in     = byte1_ff;

      // input register load and release
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_item_in  = req_data;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      // move the item into the result buffer, or drain one byte
      if (advance) begin
         res_count_in = nbytes;
         byte0_in     = window[23:16];
         byte1_in     = window[15:8];
         if (in_item_ff.func == dcve_pkg::FUNC_FLUSH) begin
            pend_bits_in = 7'd0;
            pend_cnt_in  = 3'd0;
         end else begin
            pend_bits_in = acc[6:0] & keep_mask[6:0];
            pend_cnt_in  = total[2:0];
            pred_in      = in_item_ff.sample;
         end
      end else if (rsp_take) begin
         res_count_in = res_count_ff - 2'd1;
         byte0_in     = byte1_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         pred_ff      <= 8'd0;
         pend_bits_ff <= 7'd0;
         pend_cnt_ff  <= 3'd0;
         res_count_ff <= 2'd0;
      end else begin
         in_valid_ff  <= in_valid_in;
         pred_ff      <= pred_in;
         pend_bits_ff <= pend_bits_in;
         pend_cnt_ff  <= pend_cnt_in;
         res_count_ff <= res_count_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      in_item_ff <= in_item_in;
      byte0_ff   <= byte0_in;
      byte1_ff   <= byte1_in;
   end

   // checks on the result buffer and coding state
   `DCVE_ASSERT_NEXT(a_second_byte_follows, rsp_take && (res_count_ff == 2'd2), rsp_valid && rsp_data.last, "second byte of an item missing")
   `DCVE_ASSERT_SAME(a_no_advance_when_full, in_valid_ff && (res_count_ff == 2'd2), !req_ready && !advance, "item advanced over a full result buffer")
   `DCVE_ASSERT_NEXT(a_flush_clears_pending, advance && (in_item_ff.func == dcve_pkg::FUNC_FLUSH), (pend_cnt_ff == 3'd0) && (pend_bits_ff == 7'd0), "flush left pending bits")

endmodule

// ===== dv/dcve_stream_checker.sv =====
`timescale 1ns / 100ps
// stream checker for the dpcm category vlc encoder: predicts code bytes, compares results
// depends on dcve_pkg for the item types and function codes
module dcve_stream_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  dcve_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  dcve_pkg::rsp_type rsp_data,
   output int                mismatch_count,
   output int                waiting_bytes
);
   import dcve_pkg::*;

   // predicted encoder state
   logic [7:0] prev_sample;
   logic [6:0] carry_bits;
   logic [2:0] carry_cnt;

   // code bytes still to arrive, oldest first
   rsp_type due_bytes[$];

   initial begin
      mismatch_count = 0;
      waiting_bytes = 0;
   end

   task automatic report_mismatch(input string what);
      if (mismatch_count < 100) begin
         $display("%0t mismatch: %s", $realtime, what);
      end
      mismatch_count = mismatch_count + 1;
   endtask

   // bit stream prediction for one accepted item
   task automatic encode_item(input req_type item);
      logic [7:0]  base;
      logic        neg;
      logic [8:0]  mag;
      logic [8:0]  mbits;
      logic [5:0]  pcode;
      logic [20:0] acc;
      int unsigned cat;
      int unsigned plen;
      int unsigned total;
      int unsigned n;
      logic [7:0]  bytes_out[2];
      rsp_type     r;
      if (item.func == FUNC_FLUSH) begin
         // pad carried bits with zeros, nothing out when empty
         if (carry_cnt != 3'd0) begin
            r.out_byte = 8'({1'b0, carry_bits} << (4'd8 - carry_cnt));
            r.last = 1'b1;
            due_bytes.push_back(r);
         end
         carry_bits = '0;
         carry_cnt = '0;
      end else begin
         // difference against the previous sample, zero at plane start
         base = item.plane_start ? 8'd0 : prev_sample;
         neg = item.sample < base;
         mag = neg ? ({1'b0, base} - {1'b0, item.sample})
                   : ({1'b0, item.sample} - {1'b0, base});
         cat = 0;
         for (int i = 0; i < 9; i++) begin
            if (mag[i]) cat = i + 1;
         end
         mbits = (neg ? ~mag : mag) & 9'((21'd1 << cat) - 21'd1);
         case (cat)
            0: begin pcode = 6'b000010; plen = 3; end
            1: begin pcode = 6'b000011; plen = 3; end
            2: begin pcode = 6'b000100; plen = 3; end
            3: begin pcode = 6'b000000; plen = 2; end
            4: begin pcode = 6'b000101; plen = 3; end
            5: begin pcode = 6'b000110; plen = 3; end
            6: begin pcode = 6'b001110; plen = 4; end
            7: begin pcode = 6'b011110; plen = 5; end
            default: begin pcode = 6'b111110; plen = 6; end
         endcase
         // carried bits, then prefix, then magnitude bits
         acc = 21'(carry_bits) & ((21'd1 << carry_cnt) - 21'd1);
         acc = (acc << plen) | 21'(pcode);
         acc = (acc << cat) | 21'(mbits);
         total = carry_cnt + plen + cat;
         n = 0;
         while (total >= 8 && n < 2) begin
            bytes_out[n] = 8'(acc >> (total - 8));
            total = total - 8;
            n = n + 1;
         end
         for (int j = 0; j < n; j++) begin
            r.out_byte = bytes_out[j];
            r.last = (j == n - 1);
            due_bytes.push_back(r);
         end
         carry_cnt = 3'(total);
         carry_bits = 7'(acc & ((21'd1 << total) - 21'd1));
         prev_sample = item.sample;
      end
   endtask

   // compare results first, then predict from the item taken at the same edge
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         prev_sample = '0;
         carry_bits = '0;
         carry_cnt = '0;
         due_bytes.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (due_bytes.size() == 0) begin
               report_mismatch($sformatf("unexpected byte %02h last %0b",
                                         rsp_data.out_byte, rsp_data.last));
            end else begin
               want = due_bytes.pop_front();
               if (rsp_data.out_byte !== want.out_byte) begin
                  report_mismatch($sformatf("out_byte %02h, want %02h",
                                            rsp_data.out_byte, want.out_byte));
               end
               if (rsp_data.last !== want.last) begin
                  report_mismatch($sformatf("last %0b, want %0b on byte %02h",
                                            rsp_data.last, want.last, want.out_byte));
               end
            end
         end
         if (req_valid && req_ready) begin
            encode_item(req_data);
         end
      end
      waiting_bytes <= due_bytes.size();
   end

endmodule

// ===== dv/dpcm_category_vlc_encoder_core_tb.sv =====
`timescale 1ns / 100ps
// testbench top for the dpcm category vlc encoder core: stimulus, idling and verdict
// depends on dcve_pkg, dpcm_category_vlc_encoder_core and dcve_stream_checker
module dpcm_category_vlc_encoder_core_tb;
   import dcve_pkg::*;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;
   int      mismatch_count;
   int      waiting_bytes;

   int          send_idle_pct = 17;
   int          recv_idle_pct = 61;
   logic [7:0]  last_sample = 8'd0;

   always #5 clock = ~clock;

   dpcm_category_vlc_encoder_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   dcve_stream_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatch_count),
      .waiting_bytes  (waiting_bytes)
   );

   // result side back-pressure
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // present one item, return at the edge that accepts it
   task automatic send_item(input req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_code(input logic [7:0] s, input logic ps);
      req_type item;
      item.func = FUNC_CODE;
      item.sample = s;
      item.plane_start = ps;
      send_item(item);
      last_sample = s;
   endtask

   task automatic send_flush(input logic [7:0] junk, input logic ps);
      req_type item;
      item.func = FUNC_FLUSH;
      item.sample = junk;
      item.plane_start = ps;
      send_item(item);
   endtask

   // run limit
   initial begin
      #2000000;
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      int          k;
      int          pick;
      logic [7:0]  delta;
      logic [7:0]  s;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      rsp_ready <= 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: zero difference, each category both ways, flushes
      send_code(8'd0, 1'b1);
      send_code(8'd0, 1'b0);
      send_code(8'd1, 1'b0);
      send_code(8'd3, 1'b0);
      send_code(8'd7, 1'b0);
      send_code(8'd15, 1'b0);
      send_code(8'd31, 1'b0);
      send_code(8'd63, 1'b0);
      send_code(8'd127, 1'b0);
      send_code(8'd255, 1'b0);
      send_flush(8'd0, 1'b0);
      send_flush(8'd0, 1'b0);
      send_code(8'd254, 1'b0);
      send_code(8'd252, 1'b0);
      send_code(8'd248, 1'b0);
      send_code(8'd240, 1'b0);
      send_code(8'd224, 1'b0);
      send_code(8'd192, 1'b0);
      send_code(8'd128, 1'b0);
      send_code(8'd0, 1'b0);
      // flush ignores its sample and plane start, predictor kept
      send_flush(8'hAA, 1'b1);
      send_code(8'd255, 1'b0);
      send_code(8'd0, 1'b0);
      send_code(8'd200, 1'b1);
      send_flush(8'h55, 1'b0);

      // random part in three idling phases
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin send_idle_pct = 17; recv_idle_pct = 61; end
            1: begin send_idle_pct = 61; recv_idle_pct = 17; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         for (int n = 0; n < 610; n++) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
               send_flush(8'($urandom), 1'($urandom));
            end else begin
               // near the last sample most of the time, so small categories show up
               if (pick < 60) begin
                  k = $urandom_range(8);
                  delta = 8'($urandom_range((1 << k) - 1));
                  s = $urandom_range(1) ? last_sample + delta : last_sample - delta;
               end else begin
                  s = 8'($urandom);
               end
               send_code(s, ($urandom_range(99) < 5));
            end
         end
      end
      req_valid <= 1'b0;

      // drain, then a few more cycles for stray bytes
      @(posedge clock);
      while (waiting_bytes != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/dcve_pkg.sv
rtl/dpcm_category_vlc_encoder_core.sv
dv/dcve_stream_checker.sv
dv/dpcm_category_vlc_encoder_core_tb.sv
